### rtl/wpd_pkg.sv
// shared types and constants of the wav pcm16 parser and downmix block
// parse phase encoding, controller/datapath command and status records, result record
// no dependencies
package wpd_pkg;

  localparam int MAX_CHANNELS_DEF = 8;

  // running frame sum, wide enough for 64 channels of 16-bit samples
  localparam int MIX_W  = 24;
  localparam int CIDX_W = 7;
  localparam int DCNT_W = $clog2(MIX_W);

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [15:0] FMT_PCM   = 16'd1;
  localparam logic [15:0] PCM_BITS  = 16'd16;
  localparam logic [31:0] FMT_BYTES = 32'd16;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_RIFF  = 3'd1;
  localparam logic [2:0] ST_NO_WAVE  = 3'd2;
  localparam logic [2:0] ST_BAD_FMT  = 3'd3;
  localparam logic [2:0] ST_NO_FMT   = 3'd4;

  typedef enum logic [10:0] {
    PH_RIFF  = 11'b000_0000_0001,
    PH_RSIZE = 11'b000_0000_0010,
    PH_WAVE  = 11'b000_0000_0100,
    PH_TAG   = 11'b000_0000_1000,
    PH_SIZE  = 11'b000_0001_0000,
    PH_FMTA  = 11'b000_0010_0000,
    PH_FMTB  = 11'b000_0100_0000,
    PH_SKIP  = 11'b000_1000_0000,
    PH_DATA  = 11'b001_0000_0000,
    PH_PAD   = 11'b010_0000_0000,
    PH_IDLE  = 11'b100_0000_0000
  } phase_t;

  typedef enum logic [1:0] {
    SEQ_RUN = 2'b01,
    SEQ_DIV = 2'b10
  } seq_t;

  typedef struct packed {
    logic       tag_shift;
    logic       size_clear;
    logic       size_load;
    logic       size_sub16;
    logic       fmt_cap;
    logic       fmt_second;
    logic [2:0] idx;
    logic       rem_dec;
    logic       mix_clear;
    logic       data_low;
    logic       data_high;
    logic       pend_load;
    logic       push_now;
    logic       div_step;
    logic       push_div;
    logic       fin;
    logic [2:0] fin_status;
    logic       clear;
  } cmd_t;

  typedef struct packed {
    logic shift_riff;
    logic shift_wave;
    logic tag_fmt;
    logic tag_data;
    logic size_odd;
    logic size_zero;
    logic size_lt16;
    logic rem_zero;
    logic rem_one;
    logic fmt_ok;
    logic frame_done;
    logic div_last;
    logic q_full;
  } sts_t;

  typedef struct packed {
    logic        sample_valid;
    logic [15:0] sample_out;
    logic        finished;
    logic [2:0]  status;
    logic [31:0] rate_out;
    logic [15:0] channel_count;
  } res_t;

endpackage

### rtl/wpd_ctrl.sv
// parse controller: walks riff header and chunks, sequences the frame divide
// drives wpd_dp through wpd_pkg::cmd_t, reads wpd_pkg::sts_t
// depends on wpd_pkg
module wpd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic          s_tlast,
  input  wpd_pkg::sts_t sts,
  output wpd_pkg::cmd_t cmd
);

  wpd_pkg::phase_t phase, phase_next;
  wpd_pkg::seq_t   seq, seq_next;
  logic [2:0]      idx, idx_next;
  logic            odd_pad, odd_pad_next;
  logic            fmt_seen, fmt_seen_next;
  logic            done, done_next;
  logic            acc;
  logic            fin_req;
  logic [2:0]      fin_code;

  always_comb begin
    phase_next    = phase;
    seq_next      = seq;
    idx_next      = idx;
    odd_pad_next  = odd_pad;
    fmt_seen_next = fmt_seen;
    done_next     = done;
    fin_req       = 1'b0;
    fin_code      = wpd_pkg::ST_OK;
    cmd           = '0;
    cmd.idx       = idx;
    s_tready      = (seq == wpd_pkg::SEQ_RUN) && !sts.q_full;
    acc           = s_tvalid && s_tready;

    if (seq == wpd_pkg::SEQ_DIV) begin
      cmd.div_step = 1'b1;
      if (sts.div_last) begin
        cmd.push_div = 1'b1;
        seq_next     = wpd_pkg::SEQ_RUN;
      end
    end

    if (acc) begin
      case (phase)
        wpd_pkg::PH_RIFF, wpd_pkg::PH_WAVE, wpd_pkg::PH_TAG: begin
          cmd.tag_shift = 1'b1;
          idx_next      = idx + 3'd1;
          if (idx >= 3'd3) begin
            idx_next = 3'd0;
            if (phase == wpd_pkg::PH_RIFF) begin
              if (!sts.shift_riff) begin
                fin_req  = 1'b1;
                fin_code = wpd_pkg::ST_NO_RIFF;
              end else begin
                phase_next = wpd_pkg::PH_RSIZE;
              end
            end else if (phase == wpd_pkg::PH_WAVE) begin
              if (!sts.shift_wave) begin
                fin_req  = 1'b1;
                fin_code = wpd_pkg::ST_NO_WAVE;
              end else begin
                phase_next = wpd_pkg::PH_TAG;
              end
            end else begin
              cmd.size_clear = 1'b1;
              phase_next     = wpd_pkg::PH_SIZE;
            end
          end
        end
        wpd_pkg::PH_RSIZE: begin
          idx_next = idx + 3'd1;
          if (idx >= 3'd3) begin
            idx_next   = 3'd0;
            phase_next = wpd_pkg::PH_WAVE;
          end
        end
        wpd_pkg::PH_SIZE: begin
          cmd.size_load = 1'b1;
          idx_next      = idx + 3'd1;
          if (idx >= 3'd3) begin
            // chunk size complete
            odd_pad_next = sts.size_odd;
            idx_next     = 3'd0;
            if (sts.tag_fmt) begin
              if (sts.size_lt16) begin
                fin_req  = 1'b1;
                fin_code = wpd_pkg::ST_BAD_FMT;
              end else begin
                cmd.size_sub16 = 1'b1;
                phase_next     = wpd_pkg::PH_FMTA;
              end
            end else if (sts.tag_data) begin
              if (!fmt_seen) begin
                fin_req  = 1'b1;
                fin_code = wpd_pkg::ST_NO_FMT;
              end else if (!sts.fmt_ok) begin
                fin_req  = 1'b1;
                fin_code = wpd_pkg::ST_BAD_FMT;
              end else if (sts.size_zero) begin
                phase_next = sts.size_odd ? wpd_pkg::PH_PAD : wpd_pkg::PH_TAG;
              end else begin
                cmd.mix_clear = 1'b1;
                phase_next    = wpd_pkg::PH_DATA;
              end
            end else if (sts.size_zero) begin
              phase_next = sts.size_odd ? wpd_pkg::PH_PAD : wpd_pkg::PH_TAG;
            end else begin
              phase_next = wpd_pkg::PH_SKIP;
            end
          end
        end
        wpd_pkg::PH_FMTA: begin
          cmd.fmt_cap = 1'b1;
          idx_next    = idx + 3'd1;
          if (idx == 3'd7) begin
            phase_next = wpd_pkg::PH_FMTB;
          end
        end
        wpd_pkg::PH_FMTB: begin
          cmd.fmt_cap    = 1'b1;
          cmd.fmt_second = 1'b1;
          idx_next       = idx + 3'd1;
          if (idx == 3'd7) begin
            fmt_seen_next = 1'b1;
            idx_next      = 3'd0;
            if (sts.rem_zero) begin
              phase_next = odd_pad ? wpd_pkg::PH_PAD : wpd_pkg::PH_TAG;
            end else begin
              phase_next = wpd_pkg::PH_SKIP;
            end
          end
        end
        wpd_pkg::PH_SKIP: begin
          cmd.rem_dec = 1'b1;
          if (sts.rem_one) begin
            phase_next = odd_pad ? wpd_pkg::PH_PAD : wpd_pkg::PH_TAG;
            idx_next   = 3'd0;
          end
        end
        wpd_pkg::PH_PAD: begin
          phase_next = wpd_pkg::PH_TAG;
          idx_next   = 3'd0;
        end
        wpd_pkg::PH_DATA: begin
          cmd.rem_dec = 1'b1;
          if (!idx[0]) begin
            cmd.data_low = 1'b1;
            idx_next     = 3'd1;
          end else begin
            cmd.data_high = 1'b1;
            idx_next      = 3'd0;
            if (sts.frame_done) begin
              cmd.pend_load = 1'b1;
              seq_next      = wpd_pkg::SEQ_DIV;
            end
          end
          if (sts.rem_one) begin
            fin_req  = 1'b1;
            fin_code = wpd_pkg::ST_OK;
          end
        end
        default: begin
        end
      endcase

      if (fin_req) begin
        done_next  = 1'b1;
        phase_next = wpd_pkg::PH_IDLE;
      end

      // early end of file
      if (s_tlast && !done_next) begin
        fin_req = 1'b1;
        if (phase_next == wpd_pkg::PH_RIFF) begin
          fin_code = wpd_pkg::ST_NO_RIFF;
        end else if (phase_next == wpd_pkg::PH_RSIZE || phase_next == wpd_pkg::PH_WAVE) begin
          fin_code = wpd_pkg::ST_NO_WAVE;
        end else if (fmt_seen_next && sts.fmt_ok) begin
          fin_code = wpd_pkg::ST_OK;
        end else begin
          fin_code = wpd_pkg::ST_BAD_FMT;
        end
      end

      cmd.fin        = fin_req;
      cmd.fin_status = fin_code;
      if (!cmd.pend_load && fin_req) begin
        cmd.push_now = 1'b1;
      end

      if (s_tlast) begin
        phase_next    = wpd_pkg::PH_RIFF;
        idx_next      = 3'd0;
        odd_pad_next  = 1'b0;
        fmt_seen_next = 1'b0;
        done_next     = 1'b0;
        cmd.clear     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= wpd_pkg::PH_RIFF;
      seq      <= wpd_pkg::SEQ_RUN;
      idx      <= 3'd0;
      odd_pad  <= 1'b0;
      fmt_seen <= 1'b0;
      done     <= 1'b0;
    end else begin
      phase    <= phase_next;
      seq      <= seq_next;
      idx      <= idx_next;
      odd_pad  <= odd_pad_next;
      fmt_seen <= fmt_seen_next;
      done     <= done_next;
    end
  end

endmodule

### rtl/wpd_dp.sv
// parse datapath: tag and size registers, fmt fields, frame sum, serial divider,
// two-entry result queue toward the output stream
// depends on wpd_pkg
module wpd_dp #(
  parameter int MAX_CHANNELS = wpd_pkg::MAX_CHANNELS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    byte_in,
  input  wpd_pkg::cmd_t cmd,
  output wpd_pkg::sts_t sts,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [71:0]   m_tdata,
  output logic [1:0]    m_tuser
);

  localparam int DIV_W = $clog2(MAX_CHANNELS + 1);

  logic [31:0]              tag_shift;
  logic [31:0]              chunk_rem;
  logic [15:0]              format_code;
  logic [15:0]              channel_total;
  logic [15:0]              sample_bits;
  logic [31:0]              rate_reg;
  logic [7:0]               low_byte_hold;
  logic [wpd_pkg::CIDX_W-1:0] channel_index;
  logic [wpd_pkg::MIX_W-1:0]  mix_sum;

  logic [31:0]              tag_shifted;
  logic [31:0]              size_asm;
  logic [15:0]              code_n, chan_n, bits_n;
  logic [31:0]              rate_n;
  logic signed [15:0]       samp;
  logic [wpd_pkg::MIX_W-1:0]  mix_n;
  logic [wpd_pkg::CIDX_W-1:0] cidx_inc;
  logic                     frame_done;

  // serial divider
  logic                       div_neg;
  logic [wpd_pkg::MIX_W-1:0]  div_quo;
  logic [DIV_W-1:0]           div_rem;
  logic [DIV_W-1:0]           div_den;
  logic [wpd_pkg::DCNT_W-1:0] div_cnt;
  logic [DIV_W:0]             rem_sh;
  logic                       rem_ge;
  logic [DIV_W:0]             rem_diff;
  logic [wpd_pkg::MIX_W-1:0]  quo_nx;
  logic [wpd_pkg::MIX_W-1:0]  quo_signed;

  wpd_pkg::res_t res_now, pend, pend_done, push_val;
  wpd_pkg::res_t q0, q1;
  logic [1:0]    q_count;
  logic          push, pop;
  logic          push_head;

  assign tag_shifted = {tag_shift[23:0], byte_in};
  assign size_asm    = chunk_rem | ({24'd0, byte_in} << {cmd.idx[1:0], 3'b000});

  always_comb begin
    code_n = format_code;
    chan_n = channel_total;
    bits_n = sample_bits;
    rate_n = rate_reg;
    if (cmd.fmt_cap) begin
      if (!cmd.fmt_second) begin
        case (cmd.idx)
          3'd0: code_n = {8'd0, byte_in};
          3'd1: code_n[15:8] = byte_in;
          3'd2: chan_n = {8'd0, byte_in};
          3'd3: chan_n[15:8] = byte_in;
          3'd4: rate_n = {24'd0, byte_in};
          3'd5: rate_n[15:8] = byte_in;
          3'd6: rate_n[23:16] = byte_in;
          default: rate_n[31:24] = byte_in;
        endcase
      end else if (cmd.idx == 3'd6) begin
        bits_n = {8'd0, byte_in};
      end else if (cmd.idx == 3'd7) begin
        bits_n[15:8] = byte_in;
      end
    end
  end

  assign samp       = {byte_in, low_byte_hold};
  assign mix_n      = mix_sum + {{(wpd_pkg::MIX_W-16){samp[15]}}, samp};
  assign cidx_inc   = channel_index + 1'b1;
  assign frame_done = (channel_total != 16'd0) &&
                      ({{(16-wpd_pkg::CIDX_W){1'b0}}, cidx_inc} >= channel_total);

  // restoring divide, one quotient bit a cycle
  assign rem_sh     = {div_rem, div_quo[wpd_pkg::MIX_W-1]};
  assign rem_ge     = rem_sh >= {1'b0, div_den};
  assign rem_diff   = rem_sh - {1'b0, div_den};
  assign quo_nx     = {div_quo[wpd_pkg::MIX_W-2:0], rem_ge};
  assign quo_signed = div_neg ? (~quo_nx + 1'b1) : quo_nx;

  always_comb begin
    sts            = '0;
    sts.shift_riff = tag_shifted == wpd_pkg::TAG_RIFF;
    sts.shift_wave = tag_shifted == wpd_pkg::TAG_WAVE;
    sts.tag_fmt    = tag_shift == wpd_pkg::TAG_FMT;
    sts.tag_data   = tag_shift == wpd_pkg::TAG_DATA;
    sts.size_odd   = size_asm[0];
    sts.size_zero  = size_asm == 32'd0;
    sts.size_lt16  = size_asm < wpd_pkg::FMT_BYTES;
    sts.rem_zero   = chunk_rem == 32'd0;
    sts.rem_one    = chunk_rem == 32'd1;
    sts.fmt_ok     = (code_n == wpd_pkg::FMT_PCM) && (bits_n == wpd_pkg::PCM_BITS) &&
                     (chan_n != 16'd0) && (chan_n <= 16'(MAX_CHANNELS));
    sts.frame_done = frame_done;
    sts.div_last   = div_cnt == wpd_pkg::DCNT_W'(wpd_pkg::MIX_W - 1);
    sts.q_full     = q_count == 2'd2;
  end

  always_comb begin
    res_now               = '0;
    res_now.finished      = cmd.fin;
    res_now.status        = cmd.fin_status;
    res_now.rate_out      = cmd.fin ? rate_n : 32'd0;
    res_now.channel_count = cmd.fin ? chan_n : 16'd0;
    pend_done              = pend;
    pend_done.sample_valid = 1'b1;
    pend_done.sample_out   = quo_signed[15:0];
    push_val               = cmd.push_div ? pend_done : res_now;
  end

  assign push      = cmd.push_now || cmd.push_div;
  assign pop       = m_tready && (q_count != 2'd0);
  assign push_head = push && (q_count == 2'd0 || (q_count == 2'd1 && pop));

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      tag_shift     <= '0;
      chunk_rem     <= '0;
      format_code   <= '0;
      channel_total <= '0;
      sample_bits   <= '0;
      rate_reg      <= '0;
      low_byte_hold <= '0;
      channel_index <= '0;
      mix_sum       <= '0;
    end else begin
      format_code   <= code_n;
      channel_total <= chan_n;
      sample_bits   <= bits_n;
      rate_reg      <= rate_n;
      if (cmd.tag_shift) begin
        tag_shift <= tag_shifted;
      end
      if (cmd.size_clear) begin
        chunk_rem <= '0;
      end else if (cmd.size_load) begin
        chunk_rem <= cmd.size_sub16 ? (size_asm - wpd_pkg::FMT_BYTES) : size_asm;
      end else if (cmd.rem_dec) begin
        chunk_rem <= chunk_rem - 32'd1;
      end
      if (cmd.data_low) begin
        low_byte_hold <= byte_in;
      end
      if (cmd.mix_clear) begin
        channel_index <= '0;
        mix_sum       <= '0;
      end else if (cmd.data_high) begin
        if (frame_done) begin
          channel_index <= '0;
          mix_sum       <= '0;
        end else begin
          channel_index <= cidx_inc;
          mix_sum       <= mix_n;
        end
      end
    end
  end

  // divider and pending result are not touched by the end-of-file clear
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.pend_load) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_load) begin
      pend    <= res_now;
      div_neg <= mix_n[wpd_pkg::MIX_W-1];
      div_quo <= mix_n[wpd_pkg::MIX_W-1] ? (~mix_n + 1'b1) : mix_n;
      div_rem <= '0;
      div_den <= channel_total[DIV_W-1:0];
    end else if (cmd.div_step) begin
      div_quo <= quo_nx;
      div_rem <= rem_ge ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
    end
  end

  // result queue, q0 is the head
  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10: q_count <= q_count + 2'd1;
        2'b01: q_count <= q_count - 2'd1;
        default: q_count <= q_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_head) begin
      q0 <= push_val;
    end else if (pop) begin
      q0 <= q1;
    end
    if (push && !push_head) begin
      q1 <= push_val;
    end
  end

  assign m_tvalid = q_count != 2'd0;
  assign m_tdata  = {5'd0, q0.channel_count, q0.rate_out, q0.status, q0.sample_out};
  assign m_tuser  = {q0.finished, q0.sample_valid};

endmodule

### rtl/wav_pcm16_parse_downmix_unit.sv
// top level of the byte-serial wav parser with pcm16 mono downmix
// instantiates wpd_ctrl and wpd_dp; depends on wpd_pkg
//
// usage:
//   input stream: one file byte per request on s_tdata[7:0], s_tlast on the
//   final byte of a file. the parser checks riff/wave, walks the chunks,
//   captures fmt and downmixes each frame of the data chunk to one sample.
//   output stream: one result per request. m_tuser[0] flags a mono sample in
//   m_tdata[15:0], m_tuser[1] flags the end status with status, rate and
//   channel count; both may share one result.
// timing:
//   header, fmt and skipped bytes are taken one per cycle while no divide runs
//   and the queue is not full. the last byte of every audio frame starts a
//   restoring divide by the channel count, one quotient bit a cycle over the
//   24-bit frame sum; the sample enters the output queue on the final divide
//   step, and m_tvalid follows the registered queue count. a status-only
//   result enters the queue in the cycle its byte is taken.
// reset and stall:
//   rst returns the parser to the riff tag and empties the queue. results sit
//   in a two-entry queue; input is held off only while the queue is full or a
//   divide runs, so one waiting result never blocks the parser.
module wav_pcm16_parse_downmix_unit #(
  parameter int MAX_CHANNELS = wpd_pkg::MAX_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // byte_in
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // sample_out, status, rate_out, channel_count, zero pad
  output logic [1:0]  m_tuser    // sample_valid, finished
);

  wpd_pkg::cmd_t cmd;
  wpd_pkg::sts_t sts;

  // phase sequencing and handshake
  wpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .sts      (sts),
    .cmd      (cmd)
  );

  // field registers, frame sum, divider and result queue
  wpd_dp #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (s_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
